// ===== src/binary_mask_row_col_projection_core_macros.svh =====
// Assertion macros for the mask projection core.
`ifndef BINARY_MASK_ROW_COL_PROJECTION_CORE_MACROS_SVH
`define BINARY_MASK_ROW_COL_PROJECTION_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BMRCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define BMRCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define BMRCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BMRCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/bmrcp_pkg.sv =====
// Shared constants and types of the mask projection core.
package bmrcp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W  = 8;
	localparam int X_W    = 10;
	localparam int Y_W    = 10;
	localparam int CNT_W  = 11;
	localparam int SIZE_W = 11;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};
	localparam logic [SIZE_W-1:0] MAX_W_SIZE   = SIZE_W'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] MAX_H_SIZE   = SIZE_W'(MAX_HEIGHT);
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [X_W-1:0]   x;
		logic [Y_W-1:0]   y;
		logic [CNT_W-1:0] row;
		logic             row_done;
		logic             frame_done;
		logic             bit_set;
		logic             first_row;
	} stage_t;

endpackage

// ===== src/bmrcp_ifs.sv =====
// Pixel and result channel interfaces of the mask projection core.
interface bmrcp_pix_if;
	logic                        valid;
	logic                        ready;
	logic [bmrcp_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface bmrcp_res_if;
	logic                        valid;
	logic                        ready;
	logic [bmrcp_pkg::X_W-1:0]   col_index;
	logic [bmrcp_pkg::CNT_W-1:0] col_count;
	logic [bmrcp_pkg::Y_W-1:0]   row_index;
	logic [bmrcp_pkg::CNT_W-1:0] row_count;
	logic                        row_done;
	logic                        frame_done;

	modport source (output valid, output col_index, output col_count, output row_index,
		output row_count, output row_done, output frame_done, input ready);
	modport sink (input valid, input col_index, input col_count, input row_index,
		input row_count, input row_done, input frame_done, output ready);
endinterface

// ===== src/bmrcp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bmrcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/binary_mask_row_col_projection_core.sv =====
// Top level of the mask projection core: row/column set-pixel counts over a raster stream.
// An accepted pixel beat passes the stage-1 and stage-2 registers before its result beat.
// Throughput: one pixel per cycle while the result channel is ready; res.ready low stalls the pipe.
// Back-to-back hits on one column (width one) are served by write-to-read forwarding.
// Reset: positions and row count clear, width 640, height 480; column RAM is not cleared,
// the first row of each frame writes it before any read.
`include "binary_mask_row_col_projection_core_macros.svh"

module binary_mask_row_col_projection_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmrcp_pkg::ADDR_W-1:0] paddr,
	input  logic [bmrcp_pkg::DATA_W-1:0] pwdata,
	output logic [bmrcp_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	bmrcp_pix_if.sink                    pix,
	bmrcp_res_if.source                  res
);

	logic [bmrcp_pkg::SIZE_W-1:0] width_q, height_q;
	logic [bmrcp_pkg::SIZE_W-1:0] w_eff, h_eff;
	logic [bmrcp_pkg::X_W-1:0]    x_q;
	logic [bmrcp_pkg::Y_W-1:0]    y_q;
	logic [bmrcp_pkg::CNT_W-1:0]  rowcnt_q;

	bmrcp_pkg::stage_t            stg0, stg_s1;
	logic                         v_s1, v_s2;
	logic                         fwd_hit_s1;
	logic [bmrcp_pkg::CNT_W-1:0]  fwd_data_s1;
	logic [bmrcp_pkg::CNT_W-1:0]  ram_rdata, base, col_new;
	logic                         pix_acc, move1, cfg_wr;
	logic                         bit0, row_done0, frame_done0;
	logic [bmrcp_pkg::CNT_W-1:0]  row0;

	logic [bmrcp_pkg::X_W-1:0]    col_index_s2;
	logic [bmrcp_pkg::CNT_W-1:0]  col_count_s2;
	logic [bmrcp_pkg::Y_W-1:0]    row_index_s2;
	logic [bmrcp_pkg::CNT_W-1:0]  row_count_s2;
	logic                         row_done_s2, frame_done_s2;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (bmrcp_pkg::reg_idx_t'(paddr[2]))
			bmrcp_pkg::REG_WIDTH:  prdata = {{(bmrcp_pkg::DATA_W-bmrcp_pkg::SIZE_W){1'b0}}, width_q};
			bmrcp_pkg::REG_HEIGHT: prdata = {{(bmrcp_pkg::DATA_W-bmrcp_pkg::SIZE_W){1'b0}}, height_q};
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = bmrcp_pkg::SIZE_W'(1);
		end else if (width_q > bmrcp_pkg::MAX_W_SIZE) begin
			w_eff = bmrcp_pkg::MAX_W_SIZE;
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = bmrcp_pkg::SIZE_W'(1);
		end else if (height_q > bmrcp_pkg::MAX_H_SIZE) begin
			h_eff = bmrcp_pkg::MAX_H_SIZE;
		end else begin
			h_eff = height_q;
		end
	end

	// handshake
	assign move1     = v_s1 && (!v_s2 || res.ready);
	assign pix.ready = !v_s1 || move1;
	assign pix_acc   = pix.valid && pix.ready;

	// stage 0: position and row count
	assign bit0        = (pix.pixel != '0);
	assign row0        = (rowcnt_q == bmrcp_pkg::CNT_MAX) ? rowcnt_q
		: rowcnt_q + bmrcp_pkg::CNT_W'(bit0);
	assign row_done0   = ((bmrcp_pkg::SIZE_W'(x_q) + bmrcp_pkg::SIZE_W'(1)) >= w_eff);
	assign frame_done0 = row_done0 && ((bmrcp_pkg::SIZE_W'(y_q) + bmrcp_pkg::SIZE_W'(1)) >= h_eff);

	always_comb begin
		stg0.x          = x_q;
		stg0.y          = y_q;
		stg0.row        = row0;
		stg0.row_done   = row_done0;
		stg0.frame_done = frame_done0;
		stg0.bit_set    = bit0;
		stg0.first_row  = (y_q == '0);
	end

	// stage 1: column count modify
	assign base    = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign col_new = stg_s1.first_row ? bmrcp_pkg::CNT_W'(stg_s1.bit_set)
		: (base == bmrcp_pkg::CNT_MAX) ? base : base + bmrcp_pkg::CNT_W'(stg_s1.bit_set);

	bmrcp_ram #(
		.WIDTH (bmrcp_pkg::CNT_W),
		.DEPTH (bmrcp_pkg::MAX_WIDTH)
	) u_col_ram (
		.clk   (clk),
		.we    (move1),
		.waddr (stg_s1.x),
		.wdata (col_new),
		.re    (pix_acc),
		.raddr (x_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= bmrcp_pkg::WIDTH_RESET;
			height_q   <= bmrcp_pkg::HEIGHT_RESET;
			x_q        <= '0;
			y_q        <= '0;
			rowcnt_q   <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (bmrcp_pkg::reg_idx_t'(paddr[2]))
					bmrcp_pkg::REG_WIDTH:  width_q  <= pwdata[bmrcp_pkg::SIZE_W-1:0];
					bmrcp_pkg::REG_HEIGHT: height_q <= pwdata[bmrcp_pkg::SIZE_W-1:0];
					default: ;
				endcase
			end
			if (pix_acc) begin
				if (row_done0) begin
					x_q      <= '0;
					rowcnt_q <= '0;
					y_q      <= frame_done0 ? '0 : y_q + bmrcp_pkg::Y_W'(1);
				end else begin
					x_q      <= x_q + bmrcp_pkg::X_W'(1);
					rowcnt_q <= row0;
				end
			end
			if (pix_acc) begin
				fwd_hit_s1 <= move1 && (stg_s1.x == x_q);
			end else if (move1) begin
				fwd_hit_s1 <= 1'b0;
			end
			if (pix_acc) begin
				v_s1 <= 1'b1;
			end else if (move1) begin
				v_s1 <= 1'b0;
			end
			if (move1) begin
				v_s2 <= 1'b1;
			end else if (res.ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			stg_s1      <= stg0;
			fwd_data_s1 <= col_new;
		end
		if (move1) begin
			col_index_s2  <= stg_s1.x;
			col_count_s2  <= col_new;
			row_index_s2  <= stg_s1.y;
			row_count_s2  <= stg_s1.row;
			row_done_s2   <= stg_s1.row_done;
			frame_done_s2 <= stg_s1.frame_done;
		end
	end

	assign res.valid      = v_s2;
	assign res.col_index  = col_index_s2;
	assign res.col_count  = col_count_s2;
	assign res.row_index  = row_index_s2;
	assign res.row_count  = row_count_s2;
	assign res.row_done   = row_done_s2;
	assign res.frame_done = frame_done_s2;

	`BMRCP_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, !pix.ready, v_s1 && v_s2 && !res.ready)
	`BMRCP_ASSERT_NXT(a_row_end_wraps_x, clk, arst_n, pix_acc && row_done0, x_q == '0)
	`BMRCP_ASSERT_IMP(a_fwd_needs_s1, clk, arst_n, fwd_hit_s1, v_s1)
	`BMRCP_ASSERT_IMP(a_first_row_count, clk, arst_n, res.valid && res.row_index == '0,
		res.col_count <= bmrcp_pkg::CNT_W'(1))

endmodule
